// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cell writer package
// Request codes, character codes and attribute constants shared by the
// console engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_BKSP  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } t_req;

    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    localparam int unsigned POS_W  = 11;
    localparam int unsigned CELL_W = 16;

endpackage

// ===== rtl/core/text_console_cell_writer.sv =====
// ----------------------------------------------------------------------------
// Text console cell writer
// Character-cell console engine with cursor, tab, backspace, clear, scroll
// and cell read, built around one screen memory under a small sequencer.
// ----------------------------------------------------------------------------
// Every transaction runs through a sequencer that owns the single write port
// and single read port of the screen memory, so one request is handled at a
// time. A printable put, newline, carriage return or tab that does not scroll
// goes from S_EXEC to S_DONE; backspace passes S_BS_WR and cell read S_RD_WAIT.
// Clear sweeps every cell, one per cycle. A put that moves past the last
// row scrolls by copying one cell per cycle and then blanking the bottom
// row. After reset a clearing pass fills the screen with blank cells
// before the first request is accepted; configuration writes are taken at
// any time.
module text_console_cell_writer #(
    parameter int unsigned COLS = 80,
    parameter int unsigned ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [10:0] cursor_pos, [26:11] cell_data, [31:27] zero
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import tcw_pkg::*;

    localparam int unsigned NCELLS = ROWS * COLS;
    localparam int unsigned AW     = $clog2(NCELLS);
    localparam int unsigned PW     = (AW > POS_W) ? AW : POS_W;
    localparam int unsigned CW     = $clog2(COLS);
    localparam int unsigned RW     = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_EXEC,
        S_BS_WR,
        S_RD_WAIT,
        S_SCROLL,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_init;
    logic [AW-1:0]         r_cnt;
    logic [7:0]            r_fill_attr;
    logic [7:0]            r_attr;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         r_col;
    t_req                  r_req;
    logic [7:0]            r_char;
    logic [POS_W-1:0]      r_idx;
    logic [CELL_W-1:0]     r_data;
    logic                  r_cp_pend;
    logic [AW-1:0]         r_cp_addr;
    logic [CELL_W-1:0]     r_rd_data;
    logic                  r_out_valid;
    logic [POS_W-1:0]      r_pos;
    logic [CELL_W-1:0]     r_cell;

    logic [CELL_W-1:0]     screen_mem [NCELLS];

    logic [PW-1:0]         cur_pos;
    logic [PW-1:0]         idx_w;
    logic                  idx_ok;
    logic [CW:0]           col_inc;
    logic [CW:0]           tab_col;
    logic                  row_last;
    logic                  is_ctrl;
    logic                  adv_row;
    logic [CW:0]           put_col;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [CELL_W-1:0]     mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic                  s_fire;

    assign cur_pos  = PW'(r_row) * PW'(COLS) + PW'(r_col);
    assign idx_w    = PW'(r_idx);
    assign idx_ok   = (idx_w < PW'(NCELLS));
    assign col_inc  = {1'b0, r_col} + (CW + 1)'(1);
    assign tab_col  = ({1'b0, r_col} + (CW + 1)'(4)) & ~(CW + 1)'(3);
    assign row_last = (r_row == RW'(ROWS - 1));
    assign is_ctrl  = (r_char == CH_NL) || (r_char == CH_CR) || (r_char == CH_TAB);

    always_comb begin
        adv_row = 1'b0;
        put_col = col_inc;
        case (r_char)
            CH_NL: begin
                adv_row = 1'b1;
                put_col = '0;
            end
            CH_CR: begin
                put_col = '0;
            end
            CH_TAB: begin
                adv_row = (tab_col >= (CW + 1)'(COLS));
                put_col = tab_col;
            end
            default: begin
                adv_row = (col_inc >= (CW + 1)'(COLS));
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_pos[AW-1:0];
        mem_wdata = {r_attr, CH_SPACE};
        if (r_cp_pend) begin
            mem_we    = 1'b1;
            mem_waddr = r_cp_addr;
            mem_wdata = r_rd_data;
        end else begin
            unique case (r_state)
                S_FILL: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cnt;
                    mem_wdata = {r_fill_attr, CH_SPACE};
                end
                S_EXEC: begin
                    mem_we    = (r_req == REQ_PUT) && !is_ctrl;
                    mem_wdata = {r_attr, r_char};
                end
                S_BS_WR: begin
                    mem_we = 1'b1;
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
        mem_raddr = (r_state == S_SCROLL) ? r_cnt : idx_w[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= screen_mem[mem_raddr];
    end

    assign s_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_init      <= 1'b1;
            r_cnt       <= '0;
            r_fill_attr <= ATTR_RESET;
            r_attr      <= ATTR_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_cp_pend <= (r_state == S_SCROLL);
            unique case (r_state)
                S_FILL: begin
                    if (r_cnt == AW'(NCELLS - 1)) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_DONE;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        r_req   <= t_req'(s_axis_tuser);
                        r_char  <= s_axis_tdata[7:0];
                        r_idx   <= s_axis_tdata[18:8];
                        r_data  <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_req)
                        REQ_PUT: begin
                            if (adv_row) begin
                                r_col <= '0;
                                if (row_last) begin
                                    r_cnt   <= AW'(COLS);
                                    r_state <= S_SCROLL;
                                end else begin
                                    r_row   <= r_row + RW'(1);
                                    r_state <= S_DONE;
                                end
                            end else begin
                                r_col   <= put_col[CW-1:0];
                                r_state <= S_DONE;
                            end
                        end
                        REQ_BKSP: begin
                            if (r_col != '0) begin
                                r_col <= r_col - CW'(1);
                            end else if (r_row != '0) begin
                                r_row <= r_row - RW'(1);
                                r_col <= CW'(COLS - 1);
                            end
                            r_state <= S_BS_WR;
                        end
                        REQ_CLEAR: begin
                            r_row       <= '0;
                            r_col       <= '0;
                            r_cnt       <= '0;
                            r_fill_attr <= r_attr;
                            r_state     <= S_FILL;
                        end
                        REQ_READ: begin
                            r_state <= S_RD_WAIT;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_BS_WR: begin
                    r_state <= S_DONE;
                end
                S_RD_WAIT: begin
                    r_data  <= idx_ok ? r_rd_data : '0;
                    r_state <= S_DONE;
                end
                S_SCROLL: begin
                    r_cp_addr <= r_cnt - AW'(COLS);
                    if (r_cnt == AW'(NCELLS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                S_DRAIN: begin
                    r_cnt       <= AW'((ROWS - 1) * COLS);
                    r_fill_attr <= r_attr;
                    r_state     <= S_FILL;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_pos       <= cur_pos[POS_W-1:0];
                        r_cell      <= r_data;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_cell, r_pos};
    assign o_cfg_ready   = 1'b1;

endmodule
